// File: design/assert_macros.svh
// Assertion macros shared by the connection tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("invariant violated");
`define TCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`else
`define TCT_ASSERT(lbl, clk, rst_n, prop)
`define TCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/tct_pkg.sv
// Types, codes and constants of the TCP connection tracker.
`timescale 1ns / 1ps
`default_nettype none
package tct_pkg;

    localparam int WIN_W  = 13;
    localparam int RING_W = 12;
    localparam logic [WIN_W-1:0] WINDOW_SIZE = 13'd4096;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [2:0] OP_SEGMENT = 3'd0;
    localparam logic [2:0] OP_CONNECT = 3'd1;
    localparam logic [2:0] OP_LISTEN  = 3'd2;
    localparam logic [2:0] OP_CLOSE   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic [4:0] FL_FIN = 5'h01;
    localparam logic [4:0] FL_SYN = 5'h02;
    localparam logic [4:0] FL_RST = 5'h04;
    localparam logic [4:0] FL_ACK = 5'h10;

    localparam int SEG_FIN_BIT = 0;
    localparam int SEG_SYN_BIT = 1;
    localparam int SEG_RST_BIT = 2;
    localparam int SEG_ACK_BIT = 4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_IGNORED  = 2'd1;
    localparam logic [1:0] STAT_NOT_CONN = 2'd2;

    localparam logic [2:0] CODE_CLOSED   = 3'd0;
    localparam logic [2:0] CODE_LISTEN   = 3'd1;
    localparam logic [2:0] CODE_SYNSENT  = 3'd2;
    localparam logic [2:0] CODE_SYNRECV  = 3'd3;
    localparam logic [2:0] CODE_ESTAB    = 3'd4;
    localparam logic [2:0] CODE_FINWAIT1 = 3'd5;
    localparam logic [2:0] CODE_LASTACK  = 3'd6;

    typedef enum logic [6:0] {
        ST_CLOSED   = 7'b0000001,
        ST_LISTEN   = 7'b0000010,
        ST_SYNSENT  = 7'b0000100,
        ST_SYNRECV  = 7'b0001000,
        ST_ESTAB    = 7'b0010000,
        ST_FINWAIT1 = 7'b0100000,
        ST_LASTACK  = 7'b1000000
    } conn_st_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] payload_len;
        logic [12:0] read_count;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [4:0]  send_flags;
        logic [31:0] seq_out;
        logic [31:0] ack_out;
        logic [12:0] window_out;
        logic [2:0]  conn_state;
        logic [15:0] data_skip;
        logic [12:0] data_count;
        logic [11:0] ring_addr;
        logic [1:0]  status;
        logic        last;
    } res_t;

    typedef struct packed {
        logic push;
        logic two;
        res_t r0;
        res_t r1;
    } push_t;

    function automatic logic [2:0] state_to_code(conn_st_t st);
        logic [2:0] code;
        unique case (st)
            ST_CLOSED:   code = CODE_CLOSED;
            ST_LISTEN:   code = CODE_LISTEN;
            ST_SYNSENT:  code = CODE_SYNSENT;
            ST_SYNRECV:  code = CODE_SYNRECV;
            ST_ESTAB:    code = CODE_ESTAB;
            ST_FINWAIT1: code = CODE_FINWAIT1;
            ST_LASTACK:  code = CODE_LASTACK;
            default:     code = CODE_CLOSED;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// File: design/tct_in_if.sv
// Input channel: commands and received segment headers.
`timescale 1ns / 1ps
`default_nettype none
interface tct_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] seg_window;
    logic [15:0] payload_len;
    logic [12:0] read_count;

    modport source (
        output valid, opcode, seg_flags, seg_seq, seg_ack, seg_window,
               payload_len, read_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, seg_flags, seg_seq, seg_ack, seg_window,
               payload_len, read_count,
        output ready
    );
endinterface
`default_nettype wire

// File: design/tct_out_if.sv
// Result channel: segment send requests and ring transfers.
`timescale 1ns / 1ps
`default_nettype none
interface tct_out_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [4:0]  send_flags;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [12:0] window_out;
    logic [2:0]  conn_state;
    logic [15:0] data_skip;
    logic [12:0] data_count;
    logic [11:0] ring_addr;
    logic [1:0]  status;
    logic        last;

    modport source (
        output valid, send_valid, send_flags, seq_out, ack_out, window_out,
               conn_state, data_skip, data_count, ring_addr, status, last,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_flags, seq_out, ack_out, window_out,
               conn_state, data_skip, data_count, ring_addr, status, last,
        output ready
    );
endinterface
`default_nettype wire

// File: design/tct_in_stage.sv
// Input register holding one command or segment beat.
`timescale 1ns / 1ps
`default_nettype none
module tct_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tct_in_if.sink          cmd,
    input  wire logic       take,
    output tct_pkg::item_t  item,
    output logic            item_vld
);

    logic           vld_reg;
    logic           vld_next;
    tct_pkg::item_t item_reg;
    logic           accept;

    assign cmd.ready = !vld_reg || take;
    assign accept    = cmd.valid && cmd.ready;
    assign vld_next  = accept ? 1'b1 : (take ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode      <= cmd.opcode;
            item_reg.seg_flags   <= cmd.seg_flags;
            item_reg.seg_seq     <= cmd.seg_seq;
            item_reg.seg_ack     <= cmd.seg_ack;
            item_reg.payload_len <= cmd.payload_len;
            item_reg.read_count  <= cmd.read_count;
        end
    end

    assign item     = item_reg;
    assign item_vld = vld_reg;

endmodule
`default_nettype wire

// File: design/tct_engine.sv
// Connection state, sequence and window registers with the per-beat update logic.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tct_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tct_pkg::item_t item,
    input  wire logic           fire,
    output tct_pkg::push_t      push
);

    localparam int PAD_W = 32 - tct_pkg::WIN_W;

    tct_pkg::conn_st_t        st_reg,  st_next;
    logic [31:0]              snd_reg, snd_next;
    logic [31:0]              rcv_reg, rcv_next;
    logic [tct_pkg::WIN_W-1:0] wnd_reg, wnd_next;

    logic        fin, syn, rst, ackf;
    logic        acc_ack;

    logic [31:0] off;
    logic [31:0] neg_off;
    logic [31:0] end_off;
    logic [31:0] win32;
    logic        pl_ok;
    logic [15:0] pl_skip;
    logic [16:0] pl_left;
    logic [tct_pkg::WIN_W-1:0] pl_cnt;

    logic [tct_pkg::WIN_W-1:0] rd_pend;
    logic [tct_pkg::WIN_W-1:0] rd_cnt;
    logic [31:0]               rd_start;

    logic        two;
    logic        r0_vld;
    logic [4:0]  r0_flags;
    logic [15:0] r0_skip;
    logic [12:0] r0_cnt;
    logic [11:0] r0_addr;
    logic [1:0]  r0_status;
    logic        estab_close;

    assign fin  = item.seg_flags[tct_pkg::SEG_FIN_BIT];
    assign syn  = item.seg_flags[tct_pkg::SEG_SYN_BIT];
    assign rst  = item.seg_flags[tct_pkg::SEG_RST_BIT];
    assign ackf = item.seg_flags[tct_pkg::SEG_ACK_BIT];
    assign acc_ack = ackf && !syn;

    // Payload placement against the receive edge, modulo 2^32.
    assign off     = item.seg_seq - rcv_reg;
    assign neg_off = 32'd0 - off;
    assign end_off = off + {16'd0, item.payload_len} - 32'd1;
    assign win32   = {{PAD_W{1'b0}}, wnd_reg};
    assign pl_ok   = (wnd_reg != '0)
                  && ((off == 32'd0) || ((off >= win32) && (end_off < win32)));
    assign pl_skip = (pl_ok && (off != 32'd0)) ? neg_off[15:0] : 16'd0;
    assign pl_left = {1'b0, item.payload_len} - {1'b0, pl_skip};

    always_comb
    begin
        if (!pl_ok)
        begin
            pl_cnt = '0;
        end
        else if (pl_left > {{(17 - tct_pkg::WIN_W){1'b0}}, wnd_reg})
        begin
            pl_cnt = wnd_reg;
        end
        else
        begin
            pl_cnt = pl_left[tct_pkg::WIN_W-1:0];
        end
    end

    assign rd_pend  = (wnd_reg < tct_pkg::WINDOW_SIZE) ? (tct_pkg::WINDOW_SIZE - wnd_reg) : '0;
    assign rd_cnt   = (item.read_count < rd_pend) ? item.read_count : rd_pend;
    assign rd_start = rcv_reg - {{PAD_W{1'b0}}, rd_pend};

    always_comb
    begin
        st_next   = st_reg;
        snd_next  = snd_reg;
        rcv_next  = rcv_reg;
        wnd_next  = wnd_reg;
        two       = 1'b0;
        r0_vld    = 1'b0;
        r0_flags  = 5'd0;
        r0_skip   = 16'd0;
        r0_cnt    = 13'd0;
        r0_addr   = 12'd0;
        r0_status = tct_pkg::STAT_IGNORED;

        unique case (item.opcode)
            tct_pkg::OP_SEGMENT:
            begin
                unique case (st_reg)
                    tct_pkg::ST_LISTEN:
                    begin
                        if (!rst && syn && !ackf)
                        begin
                            st_next   = tct_pkg::ST_SYNRECV;
                            snd_next  = 32'd0;
                            rcv_next  = item.seg_seq + 32'd1;
                            r0_vld    = 1'b1;
                            r0_flags  = tct_pkg::FL_SYN | tct_pkg::FL_ACK;
                            r0_status = tct_pkg::STAT_OK;
                        end
                    end
                    tct_pkg::ST_SYNSENT:
                    begin
                        if (!rst && syn && ackf)
                        begin
                            st_next   = tct_pkg::ST_ESTAB;
                            snd_next  = item.seg_ack;
                            rcv_next  = item.seg_seq + 32'd1;
                            r0_vld    = 1'b1;
                            r0_flags  = tct_pkg::FL_ACK;
                            r0_status = tct_pkg::STAT_OK;
                        end
                    end
                    tct_pkg::ST_SYNRECV:
                    begin
                        if (rst)
                        begin
                            st_next   = tct_pkg::ST_CLOSED;
                            r0_status = tct_pkg::STAT_OK;
                        end
                        else
                        begin
                            if (acc_ack)
                            begin
                                st_next   = tct_pkg::ST_ESTAB;
                                rcv_next  = item.seg_seq;
                                snd_next  = item.seg_ack;
                                r0_status = tct_pkg::STAT_OK;
                            end
                            if (fin)
                            begin
                                st_next   = tct_pkg::ST_LASTACK;
                                r0_vld    = 1'b1;
                                r0_flags  = tct_pkg::FL_ACK | tct_pkg::FL_RST;
                                r0_status = tct_pkg::STAT_OK;
                            end
                        end
                    end
                    tct_pkg::ST_ESTAB:
                    begin
                        if (rst)
                        begin
                            st_next   = tct_pkg::ST_CLOSED;
                            r0_status = tct_pkg::STAT_OK;
                        end
                        else
                        begin
                            if (acc_ack)
                            begin
                                r0_status = tct_pkg::STAT_OK;
                            end
                            if (acc_ack && (item.payload_len != 16'd0))
                            begin
                                rcv_next = rcv_reg + {{PAD_W{1'b0}}, pl_cnt};
                                wnd_next = wnd_reg - pl_cnt;
                                r0_vld   = 1'b1;
                                r0_flags = tct_pkg::FL_ACK;
                                r0_skip  = pl_skip;
                                r0_cnt   = pl_cnt;
                                r0_addr  = rcv_reg[tct_pkg::RING_W-1:0];
                            end
                            if (fin)
                            begin
                                st_next   = tct_pkg::ST_CLOSED;
                                r0_status = tct_pkg::STAT_OK;
                                if (r0_vld)
                                begin
                                    two = 1'b1;
                                end
                                else
                                begin
                                    r0_vld   = 1'b1;
                                    r0_flags = tct_pkg::FL_FIN | tct_pkg::FL_RST;
                                end
                            end
                        end
                    end
                    tct_pkg::ST_FINWAIT1:
                    begin
                        if (rst || fin)
                        begin
                            st_next   = tct_pkg::ST_CLOSED;
                            r0_status = tct_pkg::STAT_OK;
                        end
                    end
                    tct_pkg::ST_LASTACK:
                    begin
                        if (rst || ackf)
                        begin
                            st_next   = tct_pkg::ST_CLOSED;
                            r0_status = tct_pkg::STAT_OK;
                        end
                    end
                    default:
                    begin
                        r0_status = tct_pkg::STAT_IGNORED;
                    end
                endcase
            end
            tct_pkg::OP_CONNECT:
            begin
                st_next   = tct_pkg::ST_SYNSENT;
                snd_next  = 32'd0;
                r0_vld    = 1'b1;
                r0_flags  = tct_pkg::FL_SYN;
                r0_status = tct_pkg::STAT_OK;
            end
            tct_pkg::OP_LISTEN:
            begin
                st_next   = tct_pkg::ST_LISTEN;
                r0_status = tct_pkg::STAT_OK;
            end
            tct_pkg::OP_CLOSE:
            begin
                if (st_reg == tct_pkg::ST_ESTAB)
                begin
                    st_next   = tct_pkg::ST_FINWAIT1;
                    r0_vld    = 1'b1;
                    r0_flags  = tct_pkg::FL_FIN | tct_pkg::FL_ACK;
                    r0_status = tct_pkg::STAT_OK;
                end
            end
            tct_pkg::OP_READ:
            begin
                if (st_reg != tct_pkg::ST_ESTAB)
                begin
                    r0_status = tct_pkg::STAT_NOT_CONN;
                end
                else
                begin
                    wnd_next  = wnd_reg + rd_cnt;
                    r0_cnt    = rd_cnt;
                    r0_addr   = rd_start[tct_pkg::RING_W-1:0];
                    r0_status = tct_pkg::STAT_OK;
                end
            end
            default:
            begin
                r0_status = tct_pkg::STAT_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= tct_pkg::ST_CLOSED;
            snd_reg <= 32'd0;
            rcv_reg <= 32'd0;
            wnd_reg <= tct_pkg::WINDOW_SIZE;
        end
        else if (fire)
        begin
            st_reg  <= st_next;
            snd_reg <= snd_next;
            rcv_reg <= rcv_next;
            wnd_reg <= wnd_next;
        end
    end

    always_comb
    begin
        push.push = fire;
        push.two  = two;

        push.r0.send_valid = r0_vld;
        push.r0.send_flags = r0_vld ? r0_flags : 5'd0;
        push.r0.seq_out    = snd_next;
        push.r0.ack_out    = rcv_next;
        push.r0.window_out = wnd_next;
        push.r0.conn_state = two ? tct_pkg::CODE_ESTAB : tct_pkg::state_to_code(st_next);
        push.r0.data_skip  = r0_skip;
        push.r0.data_count = r0_cnt;
        push.r0.ring_addr  = r0_addr;
        push.r0.status     = r0_status;
        push.r0.last       = !two;

        push.r1.send_valid = 1'b1;
        push.r1.send_flags = tct_pkg::FL_FIN | tct_pkg::FL_RST;
        push.r1.seq_out    = snd_next;
        push.r1.ack_out    = rcv_next;
        push.r1.window_out = wnd_next;
        push.r1.conn_state = tct_pkg::state_to_code(st_next);
        push.r1.data_skip  = 16'd0;
        push.r1.data_count = 13'd0;
        push.r1.ring_addr  = 12'd0;
        push.r1.status     = tct_pkg::STAT_OK;
        push.r1.last       = 1'b1;
    end

    assign estab_close = (st_reg == tct_pkg::ST_ESTAB) && (st_next == tct_pkg::ST_CLOSED);

    `TCT_ASSERT(a_wnd_bound, clk, rst_n, wnd_reg <= tct_pkg::WINDOW_SIZE)
    `TCT_ASSERT_IMPL(a_two_from_estab, clk, rst_n, fire && two, estab_close)

endmodule
`default_nettype wire

// File: design/tct_out_fifo.sv
// Result queue taking one or two result beats per update and offering one per cycle when the result side is ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tct_out_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tct_pkg::push_t push,
    output logic                room,
    tct_out_if.source           res
);

    tct_pkg::res_t                mem [tct_pkg::Q_DEPTH];
    logic [tct_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tct_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tct_pkg::Q_CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [tct_pkg::Q_CNT_W-1:0]  n_push;
    logic                         pop;
    tct_pkg::res_t                head;
    logic                         mid_fill;

    assign room   = cnt_reg <= tct_pkg::Q_CNT_W'(tct_pkg::Q_DEPTH - 2);
    assign pop    = res.valid && res.ready;
    assign n_push = push.push ? (push.two ? tct_pkg::Q_CNT_W'(2) : tct_pkg::Q_CNT_W'(1))
                              : '0;

    assign wr_ptr_next = wr_ptr_reg + n_push[tct_pkg::Q_PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + tct_pkg::Q_PTR_W'(pop);
    assign cnt_next    = cnt_reg + n_push - tct_pkg::Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem[wr_ptr_reg] <= push.r0;
            if (push.two)
            begin
                mem[wr_ptr_reg + tct_pkg::Q_PTR_W'(1)] <= push.r1;
            end
        end
    end

    assign head = mem[rd_ptr_reg];

    assign res.valid      = cnt_reg != '0;
    assign res.send_valid = head.send_valid;
    assign res.send_flags = head.send_flags;
    assign res.seq_out    = head.seq_out;
    assign res.ack_out    = head.ack_out;
    assign res.window_out = head.window_out;
    assign res.conn_state = head.conn_state;
    assign res.data_skip  = head.data_skip;
    assign res.data_count = head.data_count;
    assign res.ring_addr  = head.ring_addr;
    assign res.status     = head.status;
    assign res.last       = head.last;

    assign mid_fill = (cnt_reg != '0)
                   && (cnt_reg != tct_pkg::Q_CNT_W'(tct_pkg::Q_DEPTH));

    `TCT_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= tct_pkg::Q_CNT_W'(tct_pkg::Q_DEPTH))
    `TCT_ASSERT_IMPL(a_no_overflow, clk, rst_n, push.push, room)
    `TCT_ASSERT_IMPL(a_ptr_gap, clk, rst_n, mid_fill, wr_ptr_reg != rd_ptr_reg)

endmodule
`default_nettype wire

// File: design/tcp_connection_tracker_top.sv
// TCP connection tracker: an input beat passes the input register, then the result
// queue, before its first result beat appears.
// Throughput: one input beat per cycle; an input that yields two results
// puts two beats into the result queue, and a four-entry result queue
// paces intake when the result side stalls.
// Reset: state closed, sequence numbers zero, receive window 4096, queues empty.
`timescale 1ns / 1ps
`default_nettype none
module tcp_connection_tracker_top (
    input  wire logic clk,
    input  wire logic rst_n,
    tct_in_if.sink    cmd,
    tct_out_if.source res
);

    tct_pkg::item_t item;
    logic           item_vld;
    logic           room;
    logic           fire;
    tct_pkg::push_t push;

    assign fire = item_vld && room;

    tct_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .take     (fire),
        .item     (item),
        .item_vld (item_vld)
    );

    tct_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .fire  (fire),
        .push  (push)
    );

    tct_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .res   (res)
    );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the TCP connection tracker: directed and random traffic.
`timescale 1ns / 1ps
module tb_top;
    import tct_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = OP_READ + 3'd1;
    localparam logic [2:0] OP_SPARE_HI = '1;
    localparam logic [7:0] SPARE_FLAG_BITS = ~8'(FL_FIN | FL_SYN | FL_RST | FL_ACK);
    localparam int PHASE_BEATS = 450;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] wnd;
        logic [15:0] plen;
        logic [12:0] rd_cnt;
    } cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    tct_in_if  cmd_if();
    tct_out_if res_if();

    tcp_connection_tracker_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    logic [2:0]  conn_code;
    logic [31:0] snd_next;
    logic [31:0] snd_unacked;
    logic [15:0] peer_wnd;
    logic [31:0] rcv_next;
    logic [31:0] rcv_room;

    res_t pending_results[$];
    int   errors;
    int   beats_sent;
    int   gap_pct;
    int   stall_pct;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic res_t conn_result(input logic sv, input logic [4:0] fl,
                                         input logic [15:0] skip,
                                         input logic [12:0] cnt,
                                         input logic [11:0] addr,
                                         input logic [1:0] stat);
        res_t r;
        r.send_valid = sv;
        r.send_flags = sv ? fl : 5'd0;
        r.seq_out    = snd_next;
        r.ack_out    = rcv_next;
        r.window_out = rcv_room[12:0];
        r.conn_state = conn_code;
        r.data_skip  = skip;
        r.data_count = cnt;
        r.ring_addr  = addr;
        r.status     = stat;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic advance_connection(input cmd_t c);
        res_t        outs[$];
        logic        fin;
        logic        syn;
        logic        rst;
        logic        ackf;
        logic        acted;
        logic        ok;
        logic [31:0] off;
        logic [31:0] end_off;
        logic [31:0] skip;
        logic [31:0] cnt;
        logic [31:0] pend;
        logic [31:0] start;
        logic [11:0] addr;
        fin   = c.flags[SEG_FIN_BIT];
        syn   = c.flags[SEG_SYN_BIT];
        rst   = c.flags[SEG_RST_BIT];
        ackf  = c.flags[SEG_ACK_BIT];
        acted = 1'b0;
        case (c.opcode)
            OP_SEGMENT:
            begin
                if (conn_code == CODE_LISTEN)
                begin
                    if (!rst && syn && !ackf)
                    begin
                        conn_code   = CODE_SYNRECV;
                        snd_next    = '0;
                        snd_unacked = '0;
                        rcv_next    = c.seq + 32'd1;
                        outs.push_back(conn_result(1'b1, FL_SYN | FL_ACK, 0, 0, 0, STAT_OK));
                    end
                end
                else if (conn_code == CODE_SYNSENT)
                begin
                    if (!rst && syn && ackf)
                    begin
                        conn_code   = CODE_ESTAB;
                        snd_next    = c.ack;
                        snd_unacked = c.ack;
                        rcv_next    = c.seq + 32'd1;
                        peer_wnd    = c.wnd;
                        outs.push_back(conn_result(1'b1, FL_ACK, 0, 0, 0, STAT_OK));
                    end
                end
                else if (conn_code >= CODE_SYNRECV && conn_code <= CODE_LASTACK)
                begin
                    if (rst)
                    begin
                        conn_code = CODE_CLOSED;
                        acted     = 1'b1;
                    end
                    else if (conn_code == CODE_FINWAIT1)
                    begin
                        if (fin)
                        begin
                            conn_code = CODE_CLOSED;
                            acted     = 1'b1;
                        end
                    end
                    else if (conn_code == CODE_ESTAB)
                    begin
                        if (ackf && !syn)
                        begin
                            snd_unacked = c.ack;
                            peer_wnd    = c.wnd;
                            acted       = 1'b1;
                            if (c.plen != 16'd0)
                            begin
                                off     = c.seq - rcv_next;
                                end_off = c.seq + 32'(c.plen) - 32'd1 - rcv_next;
                                skip    = '0;
                                cnt     = '0;
                                ok      = 1'b0;
                                if (rcv_room != 32'd0)
                                begin
                                    if (off == 32'd0)
                                        ok = 1'b1;
                                    else if (off >= rcv_room && end_off < rcv_room)
                                    begin
                                        skip = 32'd0 - off;
                                        ok   = 1'b1;
                                    end
                                end
                                addr = 12'(rcv_next % 32'(WINDOW_SIZE));
                                if (ok)
                                begin
                                    cnt = 32'(c.plen) - skip;
                                    if (cnt > rcv_room)
                                        cnt = rcv_room;
                                    rcv_next = rcv_next + cnt;
                                    rcv_room = rcv_room - cnt;
                                end
                                outs.push_back(conn_result(1'b1, FL_ACK, skip[15:0],
                                                           cnt[12:0], addr, STAT_OK));
                            end
                        end
                        if (fin)
                        begin
                            conn_code = CODE_CLOSED;
                            outs.push_back(conn_result(1'b1, FL_FIN | FL_RST, 0, 0, 0,
                                                       STAT_OK));
                        end
                    end
                    else if (conn_code == CODE_SYNRECV)
                    begin
                        if (ackf && !syn)
                        begin
                            conn_code   = CODE_ESTAB;
                            rcv_next    = c.seq;
                            snd_next    = c.ack;
                            snd_unacked = c.ack;
                            peer_wnd    = c.wnd;
                            acted       = 1'b1;
                        end
                        if (fin)
                        begin
                            conn_code = CODE_LASTACK;
                            outs.push_back(conn_result(1'b1, FL_ACK | FL_RST, 0, 0, 0,
                                                       STAT_OK));
                        end
                    end
                    else if (ackf)
                    begin
                        conn_code = CODE_CLOSED;
                        acted     = 1'b1;
                    end
                end
                if (outs.size() == 0)
                    outs.push_back(conn_result(1'b0, 0, 0, 0, 0,
                                               acted ? STAT_OK : STAT_IGNORED));
            end
            OP_CONNECT:
            begin
                conn_code   = CODE_SYNSENT;
                snd_next    = '0;
                snd_unacked = '0;
                outs.push_back(conn_result(1'b1, FL_SYN, 0, 0, 0, STAT_OK));
            end
            OP_LISTEN:
            begin
                conn_code = CODE_LISTEN;
                outs.push_back(conn_result(1'b0, 0, 0, 0, 0, STAT_OK));
            end
            OP_CLOSE:
            begin
                if (conn_code == CODE_ESTAB)
                begin
                    conn_code = CODE_FINWAIT1;
                    outs.push_back(conn_result(1'b1, FL_FIN | FL_ACK, 0, 0, 0, STAT_OK));
                end
                else
                    outs.push_back(conn_result(1'b0, 0, 0, 0, 0, STAT_IGNORED));
            end
            OP_READ:
            begin
                if (conn_code != CODE_ESTAB)
                    outs.push_back(conn_result(1'b0, 0, 0, 0, 0, STAT_NOT_CONN));
                else
                begin
                    pend  = (rcv_room < 32'(WINDOW_SIZE)) ? 32'(WINDOW_SIZE) - rcv_room : '0;
                    cnt   = (32'(c.rd_cnt) < pend) ? 32'(c.rd_cnt) : pend;
                    start = rcv_next - pend;
                    rcv_room = rcv_room + cnt;
                    outs.push_back(conn_result(1'b0, 0, 0, cnt[12:0],
                                               12'(start % 32'(WINDOW_SIZE)), STAT_OK));
                end
            end
            default:
                outs.push_back(conn_result(1'b0, 0, 0, 0, 0, STAT_IGNORED));
        endcase
        outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            pending_results.push_back(outs[i]);
    endtask

    task automatic check_result();
        res_t want;
        if (pending_results.size() == 0)
        begin
            flag_error($sformatf("result beat with nothing expected, status %0d",
                                 res_if.status));
            return;
        end
        want = pending_results.pop_front();
        check_field("send_valid", res_if.send_valid, want.send_valid);
        check_field("send_flags", res_if.send_flags, want.send_flags);
        check_field("seq_out",    res_if.seq_out,    want.seq_out);
        check_field("ack_out",    res_if.ack_out,    want.ack_out);
        check_field("window_out", res_if.window_out, want.window_out);
        check_field("conn_state", res_if.conn_state, want.conn_state);
        check_field("data_skip",  res_if.data_skip,  want.data_skip);
        check_field("data_count", res_if.data_count, want.data_count);
        check_field("ring_addr",  res_if.ring_addr,  want.ring_addr);
        check_field("status",     res_if.status,     want.status);
        check_field("last",       res_if.last,       want.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            check_result();
    end

    always @(negedge clk)
    begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_beat(input cmd_t c);
        while ($urandom_range(99) < gap_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.opcode      <= c.opcode;
        cmd_if.seg_flags   <= c.flags;
        cmd_if.seg_seq     <= c.seq;
        cmd_if.seg_ack     <= c.ack;
        cmd_if.seg_window  <= c.wnd;
        cmd_if.payload_len <= c.plen;
        cmd_if.read_count  <= c.rd_cnt;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        advance_connection(c);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic cmd_t noise_cmd();
        cmd_t c;
        c.opcode = 3'($urandom_range(7));
        c.flags  = 8'($urandom);
        c.seq    = $urandom;
        c.ack    = $urandom;
        c.wnd    = 16'($urandom);
        c.plen   = 16'($urandom);
        c.rd_cnt = 13'($urandom);
        return c;
    endfunction

    function automatic cmd_t op_cmd(input logic [2:0] op);
        cmd_t c;
        c = noise_cmd();
        c.opcode = op;
        return c;
    endfunction

    function automatic cmd_t seg_cmd(input logic [7:0] fl, input logic [31:0] sq,
                                     input logic [15:0] len);
        cmd_t c;
        c = noise_cmd();
        c.opcode = OP_SEGMENT;
        c.flags  = fl;
        c.seq    = sq;
        c.plen   = len;
        return c;
    endfunction

    function automatic logic [7:0] wild(input logic [4:0] fl);
        logic [7:0] extra;
        extra = ($urandom_range(99) < 20) ? (8'($urandom) & SPARE_FLAG_BITS) : 8'd0;
        return 8'(fl) | extra;
    endfunction

    function automatic logic [15:0] data_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 90)
            return 16'($urandom_range(1, 400));
        else if (pick < 95)
            return 16'($urandom_range(401, 4096));
        return 16'($urandom_range(4097, 65535));
    endfunction

    task automatic test_closed_state();
        push_beat(seg_cmd(8'(FL_SYN), $urandom, 16'd0));
        push_beat(op_cmd(OP_CLOSE));
        push_beat(op_cmd(OP_READ));
        push_beat(op_cmd(OP_SPARE_LO));
        push_beat(op_cmd(OP_SPARE_HI));
    endtask

    task automatic test_active_open();
        cmd_t c;
        push_beat(op_cmd(OP_CONNECT));
        push_beat(seg_cmd(8'(FL_SYN | FL_ACK), '1, 16'd0));
        push_beat(seg_cmd(8'(FL_ACK), rcv_next, 16'd100));
        c = op_cmd(OP_READ);
        c.rd_cnt = '1;
        push_beat(c);
        c.rd_cnt = '0;
        push_beat(c);
        push_beat(op_cmd(OP_CLOSE));
        push_beat(seg_cmd(8'(FL_FIN), $urandom, 16'd0));
    endtask

    task automatic test_passive_open();
        push_beat(op_cmd(OP_LISTEN));
        push_beat(seg_cmd(8'(FL_RST | FL_SYN), $urandom, 16'd0));
        push_beat(seg_cmd(8'(FL_SYN), $urandom, 16'd0));
        push_beat(seg_cmd(8'(FL_FIN), $urandom, 16'd0));
        push_beat(seg_cmd(8'(FL_ACK), $urandom, 16'd0));
    endtask

    task automatic test_payload_cases();
        cmd_t c;
        push_beat(op_cmd(OP_CONNECT));
        push_beat(seg_cmd(8'(FL_SYN | FL_ACK), '0, 16'd0));
        push_beat(seg_cmd(8'(FL_ACK), rcv_next - 32'd10, 16'd50));
        push_beat(seg_cmd(8'(FL_ACK), rcv_next + 32'd5, 16'd20));
        push_beat(seg_cmd(8'(FL_ACK) | SPARE_FLAG_BITS, rcv_next, '1));
        push_beat(seg_cmd(8'(FL_ACK), rcv_next, 16'd1));
        c = op_cmd(OP_READ);
        c.rd_cnt = 13'(WINDOW_SIZE);
        push_beat(c);
        push_beat(seg_cmd(8'(FL_ACK | FL_FIN), rcv_next, 16'd30));
    endtask

    task automatic run_session();
        cmd_t c;
        int   n;
        int   pick;
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 6))
                push_beat(noise_cmd());
            return;
        end
        if ($urandom_range(1) == 1)
        begin
            push_beat(op_cmd(OP_CONNECT));
            if ($urandom_range(99) < 10)
                push_beat(noise_cmd());
            push_beat(seg_cmd(wild(FL_SYN | FL_ACK), $urandom, 16'($urandom)));
        end
        else
        begin
            push_beat(op_cmd(OP_LISTEN));
            if ($urandom_range(99) < 10)
                push_beat(noise_cmd());
            push_beat(seg_cmd(wild(FL_SYN), $urandom, 16'($urandom)));
            if ($urandom_range(99) < 10)
                push_beat(seg_cmd(wild(FL_FIN), $urandom, 16'd0));
            push_beat(seg_cmd(wild(FL_ACK), $urandom, 16'($urandom)));
        end
        n = $urandom_range(1, 16);
        for (int k = 0; k < n && conn_code == CODE_ESTAB; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                push_beat(seg_cmd(wild(($urandom_range(99) < 5) ? (FL_ACK | FL_FIN) : FL_ACK),
                                  rcv_next, data_len()));
            else if (pick < 70)
            begin
                c = op_cmd(OP_READ);
                if ($urandom_range(99) < 85)
                    c.rd_cnt = 13'($urandom_range(0, 4096));
                push_beat(c);
            end
            else if (pick < 78)
                push_beat(seg_cmd(wild(FL_ACK), ($urandom_range(1) == 1) ? $urandom :
                                  rcv_next + 32'($urandom_range(1, 100000)), data_len()));
            else if (pick < 85)
                push_beat(seg_cmd(wild(FL_ACK), $urandom, 16'd0));
            else if (pick < 90)
                push_beat(noise_cmd());
            else if (pick < 95)
                push_beat(seg_cmd(wild(FL_ACK), rcv_next - 32'($urandom_range(1, 200)),
                                  16'($urandom_range(1, 600))));
            else
                push_beat(seg_cmd(8'($urandom), rcv_next, data_len()));
            if ($urandom_range(99) < 2)
                wait_drained();
        end
        if (conn_code != CODE_ESTAB)
            return;
        case ($urandom_range(3))
            0:
            begin
                push_beat(op_cmd(OP_CLOSE));
                if ($urandom_range(1) == 1)
                    push_beat(seg_cmd(wild(FL_ACK), $urandom, 16'($urandom)));
                push_beat(seg_cmd(wild(FL_FIN), $urandom, 16'($urandom)));
            end
            1: push_beat(seg_cmd(wild(FL_ACK | FL_FIN), rcv_next,
                                 ($urandom_range(1) == 1) ? data_len() : 16'd0));
            2: push_beat(seg_cmd(wild(FL_RST), $urandom, 16'($urandom)));
            default: ;
        endcase
    endtask

    task automatic test_random_traffic();
        int target;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 49; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 49; end
                default: begin gap_pct = 17; stall_pct = 17; end
            endcase
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
                run_session();
            if (ph == 1)
                wait_drained();
        end
    endtask

    initial
    begin
        errors      = 0;
        beats_sent  = 0;
        gap_pct     = 0;
        stall_pct   = 0;
        rst_n       = 1'b0;
        conn_code   = CODE_CLOSED;
        snd_next    = '0;
        snd_unacked = '0;
        peer_wnd    = '0;
        rcv_next    = '0;
        rcv_room    = 32'(WINDOW_SIZE);
        cmd_if.valid       = 1'b0;
        cmd_if.opcode      = OP_SEGMENT;
        cmd_if.seg_flags   = '0;
        cmd_if.seg_seq     = '0;
        cmd_if.seg_ack     = '0;
        cmd_if.seg_window  = '0;
        cmd_if.payload_len = '0;
        cmd_if.read_count  = '0;
        res_if.ready       = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_closed_state();
        test_active_open();
        test_passive_open();
        test_payload_cases();
        test_random_traffic();

        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
